FILE: sv/tdpc_pkg.sv
`timescale 1ns / 1ps

package tdpc_pkg;

    // Field widths of the channel beats
    localparam int VALUE_FIELD_W = 16;
    localparam int COUNT_FIELD_W = 32;

    // Default datapath widths
    localparam int VALUE_WIDTH = 16;
    localparam int COUNT_WIDTH = 32;

    typedef struct packed {
        logic [VALUE_FIELD_W-1:0] value;
        logic                     last_in_chunk;
    } item_beat_t;

    typedef struct packed {
        logic                     is_prime;
        logic [COUNT_FIELD_W-1:0] running_count;
        logic                     chunk_done;
    } result_beat_t;

    // Remainder unit -> sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } rem_stat_t;

    // Sequencer -> top
    typedef struct packed {
        logic idle;
        logic res_valid;
        logic prime;
    } seq_stat_t;

endpackage

FILE: sv/tdpc_rem_unit.sv
`timescale 1ns / 1ps

// Restoring remainder unit, one dividend bit per cycle.
module tdpc_rem_unit #(
    parameter int VALUE_WIDTH = tdpc_pkg::VALUE_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [VALUE_WIDTH-1:0]  dividend,
    input  logic [VALUE_WIDTH-1:0]  divisor,
    output tdpc_pkg::rem_stat_t     stat
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg,  busy_next;
    logic                   done_reg,  done_next;
    logic [CNT_W-1:0]       cnt_reg,   cnt_next;
    logic [VALUE_WIDTH-1:0] dvd_reg,   dvd_next;
    logic [VALUE_WIDTH-1:0] dvs_reg,   dvs_next;
    logic [VALUE_WIDTH-1:0] rem_reg,   rem_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;

    assign trial = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // diff[MSB] set means trial < divisor: keep trial
            rem_next = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
            dvd_next = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

FILE: sv/tdpc_seq.sv
`timescale 1ns / 1ps

// Trial divisor sequencer: walks d = 2, 3, ... while d*d <= v.
module tdpc_seq #(
    parameter int VALUE_WIDTH = tdpc_pkg::VALUE_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [VALUE_WIDTH-1:0]  value,
    input  logic                    res_ready,
    input  tdpc_pkg::rem_stat_t     rem_stat,
    output logic                    rem_start,
    output logic [VALUE_WIDTH-1:0]  dividend,
    output logic [VALUE_WIDTH-1:0]  divisor,
    output tdpc_pkg::seq_stat_t     stat
);

    localparam int SQ_W = VALUE_WIDTH + 2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] v_reg,     v_next;
    logic [VALUE_WIDTH-1:0] d_reg,     d_next;
    logic [SQ_W-1:0]        dsq_reg,   dsq_next;
    logic                   prime_reg, prime_next;
    logic                   v_small;
    logic                   sq_over;

    assign v_small = (v_reg < VALUE_WIDTH'(2));
    assign sq_over = (dsq_reg > SQ_W'(v_reg));

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        d_next     = d_reg;
        dsq_next   = dsq_reg;
        prime_next = prime_reg;
        rem_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    v_next     = value;
                    d_next     = VALUE_WIDTH'(2);
                    dsq_next   = SQ_W'(4);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (v_small)
                begin
                    prime_next = 1'b0;
                    state_next = S_DONE;
                end
                else if (sq_over)
                begin
                    prime_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        d_next     = d_reg + VALUE_WIDTH'(1);
                        dsq_next   = dsq_reg + SQ_W'({d_reg, 1'b1});
                        state_next = S_CHECK;
                    end
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        d_reg     <= d_next;
        dsq_reg   <= dsq_next;
        prime_reg <= prime_next;
    end

    assign dividend        = v_reg;
    assign divisor         = d_reg;
    assign stat.idle       = (state_reg == S_IDLE);
    assign stat.res_valid  = (state_reg == S_DONE);
    assign stat.prime      = prime_reg;

endmodule

FILE: sv/trial_division_prime_counter_core.sv
`timescale 1ns / 1ps

// Trial-division primality tester with a per-chunk prime count.
// Item channel (item_valid / item_stall / item): one beat per number to test,
// with last_in_chunk marking the final number of a chunk. Result channel
// (result_valid / result_stall / result): exactly one beat per item, carrying
// is_prime, the saturating prime count of the chunk including this item, and
// chunk_done (a copy of last_in_chunk). The count clears after a closing beat.
// Each trial divisor runs on the single bit-serial remainder unit. Trials run
// for d = 2 .. floor(sqrt(v)) and stop at the first zero remainder; values
// below 4 run none. The worst 16-bit case is 65521, with 254 divisors.
// One item is in work at a time; item_stall is high while it is tested or
// parked. A finished result waits in the output register; a new item is taken
// as soon as the tester is idle, even if that register is still held.
// Stalling the result side holds result steady and parks the tester on a
// finished item until the output register frees up. Reset clears the control
// state, the count and result_valid, not the datapath registers.
module trial_division_prime_counter_core #(
    parameter int VALUE_WIDTH = tdpc_pkg::VALUE_WIDTH,
    parameter int COUNT_WIDTH = tdpc_pkg::COUNT_WIDTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  tdpc_pkg::item_beat_t     item,
    output logic                     result_valid,
    input  logic                     result_stall,
    output tdpc_pkg::result_beat_t   result
);

    tdpc_pkg::seq_stat_t    seq_stat;
    tdpc_pkg::rem_stat_t    rem_stat;
    logic                   rem_start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
    logic [VALUE_WIDTH-1:0] item_value;
    logic                   item_take;
    logic                   slot_free;
    logic                   res_take;

    // Per-chunk state and output register
    logic [COUNT_WIDTH-1:0] count_reg,     count_next;
    logic                   ovalid_reg,    ovalid_next;
    logic                   last_reg,      last_next;
    tdpc_pkg::result_beat_t obeat_reg,     obeat_next;
    logic [COUNT_WIDTH-1:0] count_inc;

    // Upper value bits beyond VALUE_WIDTH are ignored; narrower fields zero-extend
    assign item_value = VALUE_WIDTH'(item.value);

    assign item_stall = !seq_stat.idle;
    assign item_take  = item_valid && seq_stat.idle;
    assign slot_free  = !ovalid_reg || !result_stall;
    assign res_take   = seq_stat.res_valid && slot_free;

    tdpc_seq #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (item_take),
        .value     (item_value),
        .res_ready (slot_free),
        .rem_stat  (rem_stat),
        .rem_start (rem_start),
        .dividend  (dividend),
        .divisor   (divisor),
        .stat      (seq_stat)
    );

    tdpc_rem_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (dividend),
        .divisor  (divisor),
        .stat     (rem_stat)
    );

    // Saturating increment on a prime
    assign count_inc = (seq_stat.prime && (count_reg != '1)) ?
                       count_reg + COUNT_WIDTH'(1) : count_reg;

    always_comb
    begin
        count_next  = count_reg;
        ovalid_next = ovalid_reg;
        last_next   = last_reg;
        obeat_next  = obeat_reg;
        if (item_take)
        begin
            last_next = item.last_in_chunk;
        end
        if (ovalid_reg && !result_stall)
        begin
            ovalid_next = 1'b0;
        end
        if (res_take)
        begin
            ovalid_next              = 1'b1;
            obeat_next.is_prime      = seq_stat.prime;
            obeat_next.running_count = tdpc_pkg::COUNT_FIELD_W'(count_inc);
            obeat_next.chunk_done    = last_reg;
            // Closing beat shows the full count, then the chunk restarts
            count_next = last_reg ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        obeat_reg <= obeat_next;
    end

    assign result_valid = ovalid_reg;
    assign result       = obeat_reg;

endmodule

FILE: sim/prime_tally_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the prime counter, predicts every result beat
// and compares it field by field with what the core returns.
module prime_tally_checker
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  tdpc_pkg::item_beat_t   item,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  tdpc_pkg::result_beat_t result,
    output int                     errors,
    output int                     pending,
    output int                     results_seen
);

    logic [tdpc_pkg::COUNT_WIDTH-1:0] chunk_primes;
    tdpc_pkg::result_beat_t           awaited_results[$];
    int                               fail_total;
    int                               result_total;

    // Plain trial division over d = 2 .. floor(sqrt(v)).
    function automatic bit value_is_prime(logic [31:0] v);
        longint unsigned d;
        if (v < 2)
            return 1'b0;
        for (d = 2; d * d <= v; d++)
        begin
            if (v % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advances the chunk count for one number and returns its result beat.
    function automatic tdpc_pkg::result_beat_t tally_number(tdpc_pkg::item_beat_t b);
        tdpc_pkg::result_beat_t r;
        logic [31:0]            v;
        bit                     prime;
        v = 32'(b.value) & 32'((64'd1 << tdpc_pkg::VALUE_WIDTH) - 64'd1);
        prime = value_is_prime(v);
        if (prime && chunk_primes != '1)
            chunk_primes = chunk_primes + tdpc_pkg::COUNT_WIDTH'(1);
        r.is_prime      = prime;
        r.running_count = 32'(chunk_primes);
        r.chunk_done    = b.last_in_chunk;
        if (b.last_in_chunk)
            chunk_primes = '0;
        return r;
    endfunction

    initial
    begin
        errors       = 0;
        pending      = 0;
        results_seen = 0;
        fail_total   = 0;
        result_total = 0;
        chunk_primes = '0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        tdpc_pkg::result_beat_t want;
        if (!rst_n)
        begin
            chunk_primes = '0;
            awaited_results.delete();
        end
        else
        begin
            // No beat can leave on the edge that took its number in,
            // so the result side is checked first.
            if (result_valid && !result_stall)
            begin
                result_total++;
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with no number outstanding: %p", result);
                    fail_total++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.is_prime !== want.is_prime)
                    begin
                        $error("is_prime: expected %0d, actual %0d",
                               want.is_prime, result.is_prime);
                        fail_total++;
                    end
                    if (result.running_count !== want.running_count)
                    begin
                        $error("running_count: expected %0d, actual %0d",
                               want.running_count, result.running_count);
                        fail_total++;
                    end
                    if (result.chunk_done !== want.chunk_done)
                    begin
                        $error("chunk_done: expected %0d, actual %0d",
                               want.chunk_done, result.chunk_done);
                        fail_total++;
                    end
                end
            end
            if (item_valid && !item_stall)
                awaited_results.push_back(tally_number(item));
        end
        errors       <= fail_total;
        pending      <= awaited_results.size();
        results_seen <= result_total;
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the trial-division prime counter. All prediction
// and comparison lives in prime_tally_checker; this module only makes beats,
// shapes the traffic on both channels and reports the outcome.
module tb_top;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    tdpc_pkg::item_beat_t   item         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    tdpc_pkg::result_beat_t result;

    int errors;
    int pending;
    int results_seen;

    // Sender burst bookkeeping
    int burst_left = 0;
    int numbers_sent = 0;

    trial_division_prime_counter_core uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    prime_tally_checker chk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, set well beyond the slowest legal run (every number a large prime,
    // ~250 trial divisors each, plus the long result hold-off and the worst gaps).
    initial
    begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Puts one number on the item channel and returns on the edge that takes
    // it. Between bursts valid drops for a random gap; a zero gap keeps valid
    // high so back-to-back beats are exercised too.
    task automatic offer_number(input logic [tdpc_pkg::VALUE_FIELD_W-1:0] v, input bit last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                9:          gap = $urandom_range(20, 60);
                default:    gap = $urandom_range(1, 10);
            endcase
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item.value         <= v;
        item.last_in_chunk <= last;
        item_valid         <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        numbers_sent++;
    endtask

    // Drops valid and holds off until every outstanding result has come back.
    task automatic wait_drained();
        item_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Most numbers stay small: trial division cost grows with sqrt(value),
    // so full 16-bit values are kept to a minority of the beats.
    function automatic logic [tdpc_pkg::VALUE_FIELD_W-1:0] pick_number();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return tdpc_pkg::VALUE_FIELD_W'($urandom_range(0, 1023));
            5, 6, 7:       return tdpc_pkg::VALUE_FIELD_W'($urandom_range(0, 8191));
            default:       return tdpc_pkg::VALUE_FIELD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Receiver: cycles through stall patterns of its own. Once enough results
    // have passed it holds off for a long stretch so the core parks a finished
    // result, takes one more number and then stalls its input. The stretch
    // covers two worst-case numbers back to back.
    initial
    begin
        int  seg_len;
        int  mode;
        bit  held_long;
        held_long = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_long && results_seen >= 40)
            begin
                held_long = 1'b1;
                result_stall <= 1'b1;
                repeat (12000) @(posedge clk);
            end
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(20, 80);
            for (int n = 0; n < seg_len; n++)
            begin
                case (mode)
                    0:       result_stall <= 1'b0;             // free flow
                    1:       result_stall <= 1'($urandom_range(0, 1));
                    2:       result_stall <= ($urandom_range(0, 3) == 0);
                    default: result_stall <= (n < 25);         // solid block, then open
                endcase
                @(posedge clk);
            end
        end
    end

    // Sender and verdict
    initial
    begin
        int chunk_len;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: edges of primality and of chunk framing.
        offer_number(16'd0, 1'b0);       // zero is not prime
        offer_number(16'd1, 1'b0);       // one is not prime
        offer_number(16'd2, 1'b0);       // smallest prime, no divisor tried
        offer_number(16'd3, 1'b0);
        offer_number(16'd4, 1'b1);       // smallest composite closes the chunk
        offer_number(16'd2, 1'b1);       // one-beat chunk with a prime
        offer_number(16'd0, 1'b1);       // one-beat chunk with no prime
        offer_number(16'd49, 1'b0);      // prime squares: only the last divisor hits
        offer_number(16'd121, 1'b0);
        offer_number(16'd63001, 1'b0);   // 251*251, largest prime square in range
        offer_number(16'd65521, 1'b0);   // largest 16-bit prime, full trial run
        offer_number(16'd65535, 1'b0);   // all ones
        offer_number(16'd65534, 1'b0);
        offer_number(16'd32768, 1'b0);   // single high bit
        offer_number(16'd32749, 1'b1);   // largest 15-bit prime, closes chunk
        offer_number(16'd65521, 1'b1);   // prime that both counts and closes
        offer_number(16'd9, 1'b0);
        offer_number(16'd5, 1'b0);
        offer_number(16'd7, 1'b0);
        offer_number(16'd11, 1'b1);
        offer_number(16'd43690, 1'b0);   // alternating bit patterns
        offer_number(16'd21845, 1'b1);

        // Pause here until the core has returned everything.
        wait_drained();

        // Random chunks, each closed by a last beat.
        while (numbers_sent < 140)
        begin
            chunk_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 30)
                                                    : $urandom_range(1, 10);
            for (int i = 0; i < chunk_len; i++)
                offer_number(pick_number(), i == chunk_len - 1);
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
